FILE: src/baazt_pkg.sv
package baazt_pkg;

    localparam int C_DATA_W = 32;
    localparam int C_CNT_W  = 64;
    localparam int C_TYPE_W = 2;
    localparam int C_ORG_W  = 2;

    // Address space width used for the overflow check
    localparam int C_ADDR_BITS = 32;
    localparam logic [63:0] C_ADDR_LIM = (C_ADDR_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                       : ((64'd1 << C_ADDR_BITS) - 64'd1);

    localparam logic [C_TYPE_W-1:0] C_REQ_ALLOC   = 2'd0;
    localparam logic [C_TYPE_W-1:0] C_REQ_RESET   = 2'd1;
    localparam logic [C_TYPE_W-1:0] C_REQ_RECLAIM = 2'd2;

    localparam logic [C_ORG_W-1:0] C_ORG_UNKNOWN   = 2'd0;
    localparam logic [C_ORG_W-1:0] C_ORG_FRESH     = 2'd1;
    localparam logic [C_ORG_W-1:0] C_ORG_RECLAIMED = 2'd2;
    localparam logic [C_ORG_W-1:0] C_ORG_ZEROED    = 2'd3;

    localparam logic C_CFG_BASE = 1'b0;
    localparam logic C_CFG_CAP  = 1'b1;

    localparam logic [C_DATA_W-1:0] C_BASE_RST = 32'd0;
    localparam logic [C_DATA_W-1:0] C_CAP_RST  = 32'd4096;

    typedef struct packed {
        logic [C_TYPE_W-1:0] req_type;
        logic [C_DATA_W-1:0] size;
        logic [C_DATA_W-1:0] align;
        logic                zreq;
    } t_req;

    typedef struct packed {
        logic                ok;
        logic [C_DATA_W-1:0] offset;
        logic [C_DATA_W-1:0] size;
        logic [C_ORG_W-1:0]  origin;
        logic                fill;
        logic [C_CNT_W-1:0]  alloc_total;
        logic [C_CNT_W-1:0]  req_total;
        logic [C_CNT_W-1:0]  elided_total;
        logic [C_CNT_W-1:0]  explicit_total;
    } t_rsp;

endpackage

FILE: src/bump_arena_allocator_zero_tracking.sv
// A word accepted into the input register fires through the core into the output register.
// Throughput: one word per cycle while the output is not stalled; cursor, mark
// and counters update as a word fires, so a word can follow in the next cycle.
// A stalled output holds one result while one more word waits in the input stage.
// Reset (synchronous, active low) clears cursor, mark, counters and valids, and
// sets base to 0 and capacity to 4096.
module bump_arena_allocator_zero_tracking import baazt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [C_DATA_W-1:0] i_cfg_wdata,

    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [C_TYPE_W-1:0] i_req_type,
    input  logic [C_DATA_W-1:0] i_request_size,
    input  logic [C_DATA_W-1:0] i_request_alignment,
    input  logic                i_zero_request,

    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_ok,
    output logic [C_DATA_W-1:0] o_granted_offset,
    output logic [C_DATA_W-1:0] o_granted_size,
    output logic [C_ORG_W-1:0]  o_zero_origin,
    output logic                o_zero_fill_needed,
    output logic [C_CNT_W-1:0]  o_allocation_total,
    output logic [C_CNT_W-1:0]  o_requested_bytes_total,
    output logic [C_CNT_W-1:0]  o_elided_zero_total,
    output logic [C_CNT_W-1:0]  o_explicit_zero_total
);

    logic [C_DATA_W-1:0] r_base;
    logic [C_DATA_W-1:0] r_cap;
    logic                r_in_valid, n_in_valid;
    t_req                r_in;
    logic                r_out_valid, n_out_valid;
    t_rsp                r_out;
    t_rsp                rsp;
    logic                advance;
    logic                in_acc;
    logic                fire;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign fire       = r_in_valid && advance;

    always_comb begin
        n_in_valid  = in_acc ? 1'b1 : (fire ? 1'b0 : r_in_valid);
        n_out_valid = advance ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= C_BASE_RST;
            r_cap  <= C_CAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                C_CFG_BASE: r_base <= i_cfg_wdata;
                C_CFG_CAP:  r_cap  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.req_type <= i_req_type;
            r_in.size     <= i_request_size;
            r_in.align    <= i_request_alignment;
            r_in.zreq     <= i_zero_request;
        end
        if (fire) begin
            r_out <= rsp;
        end
    end

    baazt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_in),
        .i_base  (r_base),
        .i_cap   (r_cap),
        .o_rsp   (rsp)
    );

    assign o_out_valid             = r_out_valid;
    assign o_ok                    = r_out.ok;
    assign o_granted_offset        = r_out.offset;
    assign o_granted_size          = r_out.size;
    assign o_zero_origin           = r_out.origin;
    assign o_zero_fill_needed      = r_out.fill;
    assign o_allocation_total      = r_out.alloc_total;
    assign o_requested_bytes_total = r_out.req_total;
    assign o_elided_zero_total     = r_out.elided_total;
    assign o_explicit_zero_total   = r_out.explicit_total;

endmodule

FILE: src/baazt_core.sv
module baazt_core import baazt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  t_req                i_req,
    input  logic [C_DATA_W-1:0] i_base,
    input  logic [C_DATA_W-1:0] i_cap,
    output t_rsp                o_rsp
);

    logic [C_DATA_W-1:0] r_bump, n_bump;
    logic [C_DATA_W-1:0] r_mark, n_mark;
    logic                r_reclaimed, n_reclaimed;
    logic [C_CNT_W-1:0]  r_alloc_cnt, n_alloc_cnt;
    logic [C_CNT_W-1:0]  r_req_sum, n_req_sum;
    logic [C_CNT_W-1:0]  r_elided_sum, n_elided_sum;
    logic [C_CNT_W-1:0]  r_explicit_sum, n_explicit_sum;

    always_comb begin
        logic [C_DATA_W-1:0] mask;
        logic [C_DATA_W+1:0] cur;
        logic [C_DATA_W+1:0] sum;
        logic [C_DATA_W+1:0] aligned;
        logic [C_DATA_W+1:0] start;
        logic [C_DATA_W-1:0] blk_end;
        logic                pow2;
        logic                addr_ok;
        logic                fits;
        logic                known;

        mask    = i_req.align - 32'd1;
        cur     = {2'b00, i_base} + {2'b00, r_bump};
        sum     = cur + {2'b00, mask};
        aligned = sum & ~{2'b00, mask};
        start   = aligned - {2'b00, i_base};
        blk_end = start[C_DATA_W-1:0] + i_req.size;
        pow2    = (i_req.align != '0) && ((i_req.align & mask) == '0);
        // sum bounds cur and mask too, and base never exceeds cur
        addr_ok = {{(64-C_DATA_W-2){1'b0}}, sum} <= C_ADDR_LIM;
        fits    = (start <= {2'b00, i_cap})
               && ({2'b00, i_req.size} <= ({2'b00, i_cap} - start));
        known   = start[C_DATA_W-1:0] >= r_mark;

        n_bump         = r_bump;
        n_mark         = r_mark;
        n_reclaimed    = r_reclaimed;
        n_alloc_cnt    = r_alloc_cnt;
        n_req_sum      = r_req_sum;
        n_elided_sum   = r_elided_sum;
        n_explicit_sum = r_explicit_sum;

        o_rsp.ok     = 1'b0;
        o_rsp.offset = '0;
        o_rsp.size   = '0;
        o_rsp.origin = C_ORG_UNKNOWN;
        o_rsp.fill   = 1'b0;

        unique case (i_req.req_type)
            C_REQ_ALLOC: begin
                if (i_cap != '0 && i_req.size != '0 && pow2 && addr_ok && fits) begin
                    o_rsp.ok     = 1'b1;
                    o_rsp.offset = start[C_DATA_W-1:0];
                    o_rsp.size   = i_req.size;
                    if (known) begin
                        o_rsp.origin = r_reclaimed ? C_ORG_RECLAIMED : C_ORG_FRESH;
                    end
                    if (i_req.zreq) begin
                        if (known) begin
                            n_elided_sum = r_elided_sum + {32'd0, i_req.size};
                        end else begin
                            o_rsp.origin   = C_ORG_ZEROED;
                            o_rsp.fill     = 1'b1;
                            n_explicit_sum = r_explicit_sum + {32'd0, i_req.size};
                        end
                    end
                    n_bump = blk_end;
                    if (blk_end > r_mark) begin
                        n_mark = blk_end;
                    end
                    n_alloc_cnt = r_alloc_cnt + 64'd1;
                    n_req_sum   = r_req_sum + {32'd0, i_req.size};
                end
            end
            C_REQ_RESET: begin
                n_bump   = '0;
                o_rsp.ok = 1'b1;
            end
            C_REQ_RECLAIM: begin
                if (i_cap != '0 && r_bump == '0) begin
                    n_mark      = '0;
                    n_reclaimed = 1'b1;
                    o_rsp.ok    = 1'b1;
                end
            end
            default: begin
            end
        endcase

        o_rsp.alloc_total    = n_alloc_cnt;
        o_rsp.req_total      = n_req_sum;
        o_rsp.elided_total   = n_elided_sum;
        o_rsp.explicit_total = n_explicit_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bump         <= '0;
            r_mark         <= '0;
            r_reclaimed    <= 1'b0;
            r_alloc_cnt    <= '0;
            r_req_sum      <= '0;
            r_elided_sum   <= '0;
            r_explicit_sum <= '0;
        end else if (i_fire) begin
            r_bump         <= n_bump;
            r_mark         <= n_mark;
            r_reclaimed    <= n_reclaimed;
            r_alloc_cnt    <= n_alloc_cnt;
            r_req_sum      <= n_req_sum;
            r_elided_sum   <= n_elided_sum;
            r_explicit_sum <= n_explicit_sum;
        end
    end

    // cursor never passes the high-water mark
    a_bump_le_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bump <= r_mark)
        else $error("cursor above high-water mark");

    a_fill_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.fill |-> (o_rsp.ok && o_rsp.origin == C_ORG_ZEROED
                        && i_req.req_type == C_REQ_ALLOC))
        else $error("zero fill without explicit zero origin");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_alloc_cnt) && $stable(r_bump) && $stable(r_mark)))
        else $error("allocator state moved without a word");

endmodule

FILE: dv/arena_grant_checker.sv
`timescale 1ns / 100ps

module arena_grant_checker import baazt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [C_DATA_W-1:0] i_cfg_wdata,

    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [C_TYPE_W-1:0] i_req_type,
    input  logic [C_DATA_W-1:0] i_request_size,
    input  logic [C_DATA_W-1:0] i_request_alignment,
    input  logic                i_zero_request,

    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic                i_ok,
    input  logic [C_DATA_W-1:0] i_granted_offset,
    input  logic [C_DATA_W-1:0] i_granted_size,
    input  logic [C_ORG_W-1:0]  i_zero_origin,
    input  logic                i_zero_fill_needed,
    input  logic [C_CNT_W-1:0]  i_allocation_total,
    input  logic [C_CNT_W-1:0]  i_requested_bytes_total,
    input  logic [C_CNT_W-1:0]  i_elided_zero_total,
    input  logic [C_CNT_W-1:0]  i_explicit_zero_total,

    output int                  o_fail_count,
    output int                  o_pending
);

    // shadow of the allocator
    logic [C_DATA_W-1:0] arena_base;
    logic [C_DATA_W-1:0] arena_cap;
    logic [C_DATA_W-1:0] cursor;
    logic [C_DATA_W-1:0] high_mark;
    logic                reclaimed;
    logic [C_CNT_W-1:0]  alloc_cnt;
    logic [C_CNT_W-1:0]  granted_sum;
    logic [C_CNT_W-1:0]  elided_sum;
    logic [C_CNT_W-1:0]  explicit_sum;

    t_rsp pending_grants[$];
    int   mismatches = 0;

    function automatic logic is_pow2(input logic [C_DATA_W-1:0] v);
        return (v != '0) && ((v & (v - 1'b1)) == '0);
    endfunction

    function automatic t_rsp predict_grant(input t_req rq);
        t_rsp        r;
        logic [63:0] mask;
        logic [63:0] cur;
        logic [63:0] aligned;
        logic [63:0] start;
        logic [63:0] size64;
        logic [63:0] end64;
        logic        known;
        r      = '0;
        size64 = {32'd0, rq.size};
        mask   = {32'd0, rq.align} - 64'd1;
        cur    = {32'd0, arena_base} + {32'd0, cursor};
        case (rq.req_type)
            C_REQ_ALLOC: begin
                if (arena_cap != '0 && rq.size != '0 && is_pow2(rq.align) &&
                    {32'd0, arena_base} <= C_ADDR_LIM && cur <= C_ADDR_LIM &&
                    mask <= C_ADDR_LIM && cur <= C_ADDR_LIM - mask) begin
                    aligned = (cur + mask) & ~mask;
                    start   = aligned - {32'd0, arena_base};
                    if (start <= {32'd0, arena_cap} &&
                        size64 <= {32'd0, arena_cap} - start) begin
                        end64    = start + size64;
                        known    = start >= {32'd0, high_mark};
                        r.ok     = 1'b1;
                        r.offset = start[C_DATA_W-1:0];
                        r.size   = rq.size;
                        r.origin = !known ? C_ORG_UNKNOWN :
                                   reclaimed ? C_ORG_RECLAIMED : C_ORG_FRESH;
                        if (rq.zreq) begin
                            if (known) begin
                                elided_sum = elided_sum + size64;
                            end else begin
                                r.origin     = C_ORG_ZEROED;
                                r.fill       = 1'b1;
                                explicit_sum = explicit_sum + size64;
                            end
                        end
                        cursor = end64[C_DATA_W-1:0];
                        if (end64[C_DATA_W-1:0] > high_mark) begin
                            high_mark = end64[C_DATA_W-1:0];
                        end
                        alloc_cnt   = alloc_cnt + 64'd1;
                        granted_sum = granted_sum + size64;
                    end
                end
            end
            C_REQ_RESET: begin
                cursor = '0;
                r.ok   = 1'b1;
            end
            C_REQ_RECLAIM: begin
                if (arena_cap != '0 && cursor == '0) begin
                    high_mark = '0;
                    reclaimed = 1'b1;
                    r.ok      = 1'b1;
                end
            end
            default: ;
        endcase
        r.alloc_total    = alloc_cnt;
        r.req_total      = granted_sum;
        r.elided_total   = elided_sum;
        r.explicit_total = explicit_sum;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_rsp want;
        t_req rq;
        if (!i_rst_n) begin
            arena_base   = C_BASE_RST;
            arena_cap    = C_CAP_RST;
            cursor       = '0;
            high_mark    = '0;
            reclaimed    = 1'b0;
            alloc_cnt    = '0;
            granted_sum  = '0;
            elided_sum   = '0;
            explicit_sum = '0;
            pending_grants.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == C_CFG_BASE) begin
                    arena_base = i_cfg_wdata;
                end else begin
                    arena_cap = i_cfg_wdata;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_grants.size() == 0) begin
                    $error("result word with no request outstanding");
                    mismatches++;
                end else begin
                    want = pending_grants.pop_front();
                    check_field("ok", 64'(want.ok), 64'(i_ok));
                    check_field("granted_offset", 64'(want.offset),
                                64'(i_granted_offset));
                    check_field("granted_size", 64'(want.size), 64'(i_granted_size));
                    check_field("zero_origin", 64'(want.origin), 64'(i_zero_origin));
                    check_field("zero_fill_needed", 64'(want.fill),
                                64'(i_zero_fill_needed));
                    check_field("allocation_total", want.alloc_total,
                                i_allocation_total);
                    check_field("requested_bytes_total", want.req_total,
                                i_requested_bytes_total);
                    check_field("elided_zero_total", want.elided_total,
                                i_elided_zero_total);
                    check_field("explicit_zero_total", want.explicit_total,
                                i_explicit_zero_total);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                rq.req_type = i_req_type;
                rq.size     = i_request_size;
                rq.align    = i_request_alignment;
                rq.zreq     = i_zero_request;
                pending_grants.push_back(predict_grant(rq));
            end
        end
        o_pending    <= pending_grants.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top import baazt_pkg::*; ();

    localparam logic [C_TYPE_W-1:0] REQ_UNDEFINED = 2'd3;
    localparam int HOLD_CYCLES = 64;
    localparam int QUIET_LIMIT = 1000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_index = C_CFG_BASE;
    logic [C_DATA_W-1:0] i_cfg_wdata = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [C_TYPE_W-1:0] i_req_type = C_REQ_ALLOC;
    logic [C_DATA_W-1:0] i_request_size = '0;
    logic [C_DATA_W-1:0] i_request_alignment = '0;
    logic                i_zero_request = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_ok;
    logic [C_DATA_W-1:0] o_granted_offset;
    logic [C_DATA_W-1:0] o_granted_size;
    logic [C_ORG_W-1:0]  o_zero_origin;
    logic                o_zero_fill_needed;
    logic [C_CNT_W-1:0]  o_allocation_total;
    logic [C_CNT_W-1:0]  o_requested_bytes_total;
    logic [C_CNT_W-1:0]  o_elided_zero_total;
    logic [C_CNT_W-1:0]  o_explicit_zero_total;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int rx_stall_pct = 0;
    bit hold_req = 1'b0;

    bump_arena_allocator_zero_tracking dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_wdata             (i_cfg_wdata),
        .i_in_valid              (i_in_valid),
        .o_in_stall              (o_in_stall),
        .i_req_type              (i_req_type),
        .i_request_size          (i_request_size),
        .i_request_alignment     (i_request_alignment),
        .i_zero_request          (i_zero_request),
        .o_out_valid             (o_out_valid),
        .i_out_stall             (i_out_stall),
        .o_ok                    (o_ok),
        .o_granted_offset        (o_granted_offset),
        .o_granted_size          (o_granted_size),
        .o_zero_origin           (o_zero_origin),
        .o_zero_fill_needed      (o_zero_fill_needed),
        .o_allocation_total      (o_allocation_total),
        .o_requested_bytes_total (o_requested_bytes_total),
        .o_elided_zero_total     (o_elided_zero_total),
        .o_explicit_zero_total   (o_explicit_zero_total)
    );

    arena_grant_checker u_checker (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_wdata             (i_cfg_wdata),
        .i_in_valid              (i_in_valid),
        .i_in_stall              (o_in_stall),
        .i_req_type              (i_req_type),
        .i_request_size          (i_request_size),
        .i_request_alignment     (i_request_alignment),
        .i_zero_request          (i_zero_request),
        .i_out_valid             (o_out_valid),
        .i_out_stall             (i_out_stall),
        .i_ok                    (o_ok),
        .i_granted_offset        (o_granted_offset),
        .i_granted_size          (o_granted_size),
        .i_zero_origin           (o_zero_origin),
        .i_zero_fill_needed      (o_zero_fill_needed),
        .i_allocation_total      (o_allocation_total),
        .i_requested_bytes_total (o_requested_bytes_total),
        .i_elided_zero_total     (o_elided_zero_total),
        .i_explicit_zero_total   (o_explicit_zero_total),
        .o_fail_count            (fail_count),
        .o_pending               (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stall, plus one long hold-off on request
    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("bump_arena_allocator_zero_tracking regression: fail");
                $finish;
            end
        end
    end

    // valid stays high on return so back-to-back words need no second write
    task automatic send_req(input logic [C_TYPE_W-1:0] kind,
                            input logic [C_DATA_W-1:0] sz,
                            input logic [C_DATA_W-1:0] al,
                            input logic zr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_req_type          <= kind;
        i_request_size      <= sz;
        i_request_alignment <= al;
        i_zero_request      <= zr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic open_phase(input logic [C_DATA_W-1:0] base,
                              input logic [C_DATA_W-1:0] cap,
                              input int send_pct, input int rx_pct);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= C_CFG_BASE;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        i_cfg_index <= C_CFG_CAP;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        send_idle_pct = send_pct;
        rx_stall_pct  = rx_pct;
    endtask

    task automatic random_items(input int n, input logic [C_DATA_W-1:0] cap,
                                input bit squeeze);
        int                  pick;
        logic [C_DATA_W-1:0] sz;
        logic [C_DATA_W-1:0] al;
        logic [C_DATA_W-1:0] szmax;
        szmax = cap >> 4;
        if (szmax == 0) begin
            szmax = 1;
        end else if (szmax > 256) begin
            szmax = 256;
        end
        for (int i = 0; i < n; i++) begin
            if (squeeze && i == n / 3) hold_req = 1'b1;
            pick = $urandom_range(99);
            if (pick < 3) sz = '0;
            else if (pick < 8) sz = $urandom();
            else sz = $urandom_range(szmax, 1);
            pick = $urandom_range(99);
            if (pick < 4) al = '0;
            else if (pick < 9) al = $urandom();
            else if (pick < 15) al = 32'd1 << $urandom_range(31);
            else al = 32'd1 << $urandom_range(6);
            pick = $urandom_range(99);
            if (pick < 3) begin
                // cursor back to zero, then hand the pages back
                send_req(C_REQ_RESET, $urandom(), $urandom(), 1'($urandom_range(1)));
                send_req(C_REQ_RECLAIM, $urandom(), $urandom(), 1'($urandom_range(1)));
            end else if (pick < 6) begin
                send_req(C_REQ_RESET, $urandom(), $urandom(), 1'($urandom_range(1)));
            end else if (pick < 8) begin
                send_req(C_REQ_RECLAIM, $urandom(), $urandom(), 1'($urandom_range(1)));
            end else if (pick < 10) begin
                send_req(REQ_UNDEFINED, $urandom(), $urandom(), 1'($urandom_range(1)));
            end else begin
                send_req(C_REQ_ALLOC, sz, al, 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        open_phase(32'd0, 32'd4096, 0, 0);
        send_req(C_REQ_ALLOC, 32'd0, 32'd1, 1'b0);            // zero size
        send_req(C_REQ_ALLOC, 32'd16, 32'd0, 1'b1);           // zero alignment
        send_req(C_REQ_ALLOC, 32'd16, 32'd3, 1'b0);           // not a power of two
        send_req(C_REQ_ALLOC, 32'd16, 32'd1, 1'b1);           // fresh, elided
        send_req(C_REQ_ALLOC, 32'd10, 32'd8, 1'b0);
        send_req(C_REQ_ALLOC, 32'd8, 32'h8000_0000, 1'b1);    // start past capacity
        send_req(C_REQ_ALLOC, 32'hFFFF_FFFF, 32'd1, 1'b0);    // end past capacity
        send_req(C_REQ_ALLOC, 32'd4070, 32'd1, 1'b1);         // exact fit
        send_req(C_REQ_ALLOC, 32'd1, 32'd1, 1'b0);            // arena full
        send_req(C_REQ_RECLAIM, 32'd0, 32'd0, 1'b0);          // cursor still in use
        send_req(C_REQ_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_req(C_REQ_ALLOC, 32'd32, 32'd16, 1'b1);          // below mark: fill
        send_req(C_REQ_ALLOC, 32'd32, 32'd1, 1'b0);           // below mark: unknown
        send_req(C_REQ_RESET, 32'd0, 32'd0, 1'b0);
        send_req(C_REQ_RECLAIM, 32'd0, 32'd0, 1'b0);
        send_req(C_REQ_ALLOC, 32'd64, 32'd64, 1'b1);          // reclaimed, elided
        send_req(C_REQ_ALLOC, 32'd64, 32'd64, 1'b0);
        send_req(REQ_UNDEFINED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_req(C_REQ_ALLOC, 32'd1, 32'h8000_0000, 1'b0);
        random_items(400, 32'd4096, 1'b0);

        open_phase(32'h0000_1000, 32'd300, 84, 0);
        random_items(300, 32'd300, 1'b0);

        // arena at the top of the address space
        open_phase(32'hFFFF_F000, 32'h0000_2000, 0, 84);
        send_req(C_REQ_ALLOC, 32'd16, 32'h0000_2000, 1'b0);   // aligned address overflows
        send_req(C_REQ_ALLOC, 32'd16, 32'h0000_1000, 1'b1);
        send_req(C_REQ_ALLOC, 32'h0000_1000, 32'd1, 1'b0);
        random_items(300, 32'h0000_2000, 1'b0);

        open_phase(32'd0, 32'd0, 29, 29);
        random_items(100, 32'd0, 1'b0);

        open_phase(32'h7FFF_FFF0, 32'hFFFF_FFFF, 29, 29);
        random_items(300, 32'hFFFF_FFFF, 1'b0);

        open_phase(32'h0001_0000, 32'd2048, 0, 0);
        random_items(300, 32'd2048, 1'b1);

        open_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 84, 0);
        random_items(100, 32'hFFFF_FFFF, 1'b0);

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("bump_arena_allocator_zero_tracking regression: pass");
        end else begin
            $display("bump_arena_allocator_zero_tracking regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/baazt_pkg.sv
src/baazt_core.sv
src/bump_arena_allocator_zero_tracking.sv
dv/arena_grant_checker.sv
dv/tb_top.sv
